[hdl/i2cm_pkg.sv]
// Shared types and constants for the register-access I2C master.
package i2cm_pkg;

  // Input item kind codes
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_BEGIN = 2'd1;
  localparam logic [1:0] KIND_QUEUE = 2'd2;

  // Timing register reset value
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd200;

  // Data byte MSB mask and read/write bit values
  localparam logic [7:0] BYTE_MSB = 8'h80;
  localparam logic       RW_WRITE = 1'b0;
  localparam logic       RW_READ  = 1'b1;

  // Timing phase indexes within a bit
  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;
  localparam logic [1:0] PH_3 = 2'd3;

  localparam logic [2:0] LAST_BIT = 3'd7;

  // Classified command handed from front to back
  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_BEGIN,
    CMD_PUSH,
    CMD_NONE
  } cmd_e;

  // Transfer sequencer steps
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_ADDRW,
    ST_ADDRW_ACK,
    ST_REG,
    ST_REG_ACK,
    ST_WLOAD,
    ST_WDATA,
    ST_WDATA_ACK,
    ST_RSTART,
    ST_ADDRR,
    ST_ADDRR_ACK,
    ST_RDATA,
    ST_RDATA_ACK,
    ST_STOP
  } step_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic       read_not_write;
    logic [7:0] write_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       last_byte;
    logic       done_res;
    logic       status;
    logic       busy_res;
    logic       queue_full;
  } out_item_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic       read_not_write;
    logic [7:0] write_byte;
    logic       sda_in;
  } cls_item_t;

endpackage

[hdl/i2cm_front.sv]
// Front stage: accepts input beats and classifies them into commands.
module i2cm_front import i2cm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      push_valid_o,
  input  logic      push_ready_i,
  output cls_item_t push_item_o
);

  logic      valid_q, valid_d;
  cls_item_t item_q, item_d;
  logic      take;
  cmd_e      cmd;

  // Decode the kind field
  always_comb begin
    case (in_item_i.kind)
      KIND_TICK:  cmd = CMD_TICK;
      KIND_BEGIN: cmd = CMD_BEGIN;
      KIND_QUEUE: cmd = CMD_PUSH;
      default:    cmd = CMD_NONE;
    endcase
  end

  assign in_stall_o = valid_q && !push_ready_i;
  assign take       = in_valid_i && !in_stall_o;

  // Load a new beat when the stage is empty or drains this cycle
  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (valid_q && push_ready_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d                 = 1'b1;
      item_d.cmd              = cmd;
      item_d.device_address   = in_item_i.device_address;
      item_d.register_address = in_item_i.register_address;
      item_d.byte_count       = in_item_i.byte_count;
      item_d.read_not_write   = in_item_i.read_not_write;
      item_d.write_byte       = in_item_i.write_byte;
      item_d.sda_in           = in_item_i.sda_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

endmodule

[hdl/i2cm_cmd_fifo.sv]
// Two-entry command queue between the front stage and the sequencer.
module i2cm_cmd_fifo import i2cm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  cls_item_t push_item_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output cls_item_t pop_item_o
);

  cls_item_t  slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = slot_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[hdl/i2cm_engine.sv]
// Back stage: bit-phase sequencer, write byte queue and result register.
module i2cm_engine import i2cm_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] phase_ticks_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cls_item_t   cmd_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // Sequencer state
  step_e       step_q, step_d;
  logic [1:0]  phase_q, phase_d;
  logic [15:0] pcnt_q, pcnt_d;
  logic [2:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  left_q, left_d;
  logic        ack_q, ack_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic [6:0]  addr_q, addr_d;
  logic [7:0]  reg_q, reg_d;
  logic        read_q, read_d;

  // Write byte queue
  logic [7:0]       mem [QUEUE_DEPTH];
  logic [7:0]       head_data_q;
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] qcnt_q, qcnt_d;
  logic             wr_en;

  // Result register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, res;

  logic        take;
  logic        load_wr;
  logic        sclhi;
  logic        last_ph;
  logic [15:0] pt;
  logic [15:0] pcnt_inc;
  logic [7:0]  left_dec;

  assign cmd_ready_o = !out_valid_q || !out_stall_i;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign pt          = (phase_ticks_i == 16'd0) ? 16'd1 : phase_ticks_i;
  assign pcnt_inc    = pcnt_q + 16'd1;
  assign sclhi       = (phase_q == PH_1) || (phase_q == PH_2);
  assign last_ph     = (step_q == ST_STOP) ? (phase_q == PH_2) : (phase_q == PH_3);
  assign left_dec    = (left_q != 8'd0) ? left_q - 8'd1 : left_q;

  // Run one command against the sequencer
  always_comb begin
    step_d  = step_q;
    phase_d = phase_q;
    pcnt_d  = pcnt_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    left_d  = left_q;
    ack_d   = ack_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    addr_d  = addr_q;
    reg_d   = reg_q;
    read_d  = read_q;
    head_d  = head_q;
    tail_d  = tail_q;
    qcnt_d  = qcnt_q;
    wr_en   = 1'b0;
    load_wr = 1'b0;
    res     = '0;

    if (take) begin
      case (cmd_item_i.cmd)
        CMD_BEGIN: begin
          if (step_q == ST_IDLE) begin
            addr_d  = cmd_item_i.device_address;
            reg_d   = cmd_item_i.register_address;
            read_d  = cmd_item_i.read_not_write;
            left_d  = cmd_item_i.byte_count;
            if (cmd_item_i.read_not_write && (cmd_item_i.byte_count == 8'd0)) begin
              left_d = 8'd1;
            end
            ack_d   = 1'b0;
            bit_d   = 3'd0;
            shift_d = 8'd0;
            step_d  = ST_START;
            phase_d = PH_0;
            pcnt_d  = 16'd0;
          end
        end
        CMD_PUSH: begin
          if (qcnt_q >= CNT_FULL) begin
            res.queue_full = 1'b1;
          end else begin
            wr_en  = 1'b1;
            tail_d = (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
            qcnt_d = qcnt_q + CNT_W'(1);
          end
        end
        CMD_TICK: begin
          if (step_q == ST_WLOAD) begin
            load_wr = 1'b1;
          end else if (step_q != ST_IDLE) begin
            // Drive the lines for the current phase
            case (step_q)
              ST_START, ST_RSTART: begin
                case (phase_q)
                  PH_0:    sda_d = 1'b1;
                  PH_1:    begin scl_d = 1'b1; sda_d = 1'b1; end
                  PH_2:    begin scl_d = 1'b1; sda_d = 1'b0; end
                  default: begin scl_d = 1'b0; sda_d = 1'b0; end
                endcase
              end
              ST_ADDRW, ST_REG, ST_WDATA, ST_ADDRR: begin
                scl_d = sclhi;
                sda_d = (shift_q & BYTE_MSB) != 8'd0;
              end
              ST_ADDRW_ACK, ST_REG_ACK, ST_WDATA_ACK, ST_ADDRR_ACK, ST_RDATA: begin
                scl_d = sclhi;
                sda_d = 1'b1;
              end
              ST_RDATA_ACK: begin
                scl_d = sclhi;
                sda_d = (left_q <= 8'd1);
              end
              ST_STOP: begin
                scl_d = (phase_q != PH_0);
                sda_d = (phase_q == PH_2);
              end
              default: begin
              end
            endcase

            // Count ticks within the phase
            pcnt_d = pcnt_inc;
            if (pcnt_inc >= pt) begin
              pcnt_d = 16'd0;
              // Sample SDA at the end of the second high phase
              if (phase_q == PH_2) begin
                if (step_q == ST_RDATA) begin
                  shift_d = {shift_q[6:0], cmd_item_i.sda_in};
                end else if (step_q == ST_ADDRW_ACK || step_q == ST_REG_ACK ||
                             step_q == ST_WDATA_ACK || step_q == ST_ADDRR_ACK) begin
                  ack_d = !cmd_item_i.sda_in;
                end
              end
              if (!last_ph) begin
                phase_d = phase_q + 2'd1;
              end else begin
                phase_d = PH_0;
                case (step_q)
                  ST_START: begin
                    step_d  = ST_ADDRW;
                    shift_d = {addr_q, RW_WRITE};
                    bit_d   = 3'd0;
                  end
                  ST_RSTART: begin
                    step_d  = ST_ADDRR;
                    shift_d = {addr_q, RW_READ};
                    bit_d   = 3'd0;
                  end
                  ST_ADDRW, ST_REG, ST_WDATA, ST_ADDRR: begin
                    shift_d = {shift_q[6:0], 1'b0};
                    if (bit_q >= LAST_BIT) begin
                      bit_d = 3'd0;
                      case (step_q)
                        ST_ADDRW: step_d = ST_ADDRW_ACK;
                        ST_REG:   step_d = ST_REG_ACK;
                        ST_WDATA: step_d = ST_WDATA_ACK;
                        default:  step_d = ST_ADDRR_ACK;
                      endcase
                    end else begin
                      bit_d = bit_q + 3'd1;
                    end
                  end
                  ST_ADDRW_ACK, ST_REG_ACK, ST_WDATA_ACK, ST_ADDRR_ACK: begin
                    if (!ack_q) begin
                      res.done_res = 1'b1;
                      res.status   = 1'b1;
                      step_d       = ST_IDLE;
                    end else begin
                      case (step_q)
                        ST_ADDRW_ACK: begin
                          step_d  = ST_REG;
                          shift_d = reg_q;
                          bit_d   = 3'd0;
                        end
                        ST_REG_ACK: begin
                          if (read_q) begin
                            step_d = ST_RSTART;
                          end else if (left_q == 8'd0) begin
                            step_d = ST_STOP;
                          end else begin
                            load_wr = 1'b1;
                          end
                        end
                        ST_WDATA_ACK: begin
                          left_d = left_dec;
                          if (left_dec == 8'd0) begin
                            step_d = ST_STOP;
                          end else begin
                            load_wr = 1'b1;
                          end
                        end
                        default: begin
                          step_d  = ST_RDATA;
                          shift_d = 8'd0;
                          bit_d   = 3'd0;
                        end
                      endcase
                    end
                  end
                  ST_RDATA: begin
                    if (bit_q >= LAST_BIT) begin
                      bit_d          = 3'd0;
                      res.read_byte  = shift_q;
                      res.read_valid = 1'b1;
                      res.last_byte  = (left_q <= 8'd1);
                      step_d         = ST_RDATA_ACK;
                    end else begin
                      bit_d = bit_q + 3'd1;
                    end
                  end
                  ST_RDATA_ACK: begin
                    left_d = left_dec;
                    if (left_dec == 8'd0) begin
                      step_d = ST_STOP;
                    end else begin
                      step_d  = ST_RDATA;
                      shift_d = 8'd0;
                      bit_d   = 3'd0;
                    end
                  end
                  ST_STOP: begin
                    res.done_res = 1'b1;
                    step_d       = ST_IDLE;
                  end
                  default: begin
                    step_d = ST_IDLE;
                  end
                endcase
              end
            end
          end
        end
        default: begin
        end
      endcase

      // Fetch the next write byte, or wait for one
      if (load_wr) begin
        phase_d = PH_0;
        pcnt_d  = 16'd0;
        if (qcnt_q != '0) begin
          step_d  = ST_WDATA;
          shift_d = head_data_q;
          bit_d   = 3'd0;
          head_d  = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
          qcnt_d  = qcnt_q - CNT_W'(1);
        end else begin
          step_d = ST_WLOAD;
        end
      end

      res.scl      = scl_d;
      res.sda_out  = sda_d;
      res.busy_res = (step_d != ST_IDLE);
    end
  end

  // Hold the result until the receiver takes the beat
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (take) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_IDLE;
      phase_q     <= PH_0;
      pcnt_q      <= 16'd0;
      bit_q       <= 3'd0;
      shift_q     <= 8'd0;
      left_q      <= 8'd0;
      ack_q       <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      addr_q      <= 7'd0;
      reg_q       <= 8'd0;
      read_q      <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      qcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      phase_q     <= phase_d;
      pcnt_q      <= pcnt_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      left_q      <= left_d;
      ack_q       <= ack_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      addr_q      <= addr_d;
      reg_q       <= reg_d;
      read_q      <= read_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      qcnt_q      <= qcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Write the queue and prefetch the byte at the next head
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail_q] <= cmd_item_i.write_byte;
    end
    if (wr_en && (tail_q == head_d)) begin
      head_data_q <= cmd_item_i.write_byte;
    end else begin
      head_data_q <= mem[head_d];
    end
    if (take) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[hdl/i2c_master_register_access.sv]
// Top level of the register-access I2C master.
//
// Usage: every input beat is one of a tick (carries the sampled SDA level),
// a begin-transfer command, or a write byte for the byte queue. Each
// accepted input beat yields exactly one result beat carrying the driven
// SCL/SDA levels and the read, done, status, busy and queue-full flags.
// Both beat channels use valid/stall; a beat moves when valid is high and
// stall is low. The timing register (tick beats per bit phase) is written
// through the cfg valid/ready port, which is always ready; write it only
// while no transfer is running.
// Path: an input beat passes the front stage register, a command queue slot
// and the result register. Throughput: one beat per cycle while out_stall_i
// is low; a two-entry command queue decouples the classifying front stage
// from the back-stage sequencer so each side stalls on its own.
// Reset: the sequencer goes idle, lines read high, the byte queue is empty
// and the timing register returns to 200.
// Receiver stall: the result register holds its beat, the command queue and
// front stage fill, then in_stall_o rises until the result is taken.
module i2c_master_register_access import i2cm_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] ticks_q;
  logic        f_valid, f_ready;
  cls_item_t   f_item;
  logic        q_valid, q_ready;
  cls_item_t   q_item;

  // Timing register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= PHASE_TICKS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ticks_q <= cfg_data_i;
    end
  end

  i2cm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .push_valid_o (f_valid),
    .push_ready_i (f_ready),
    .push_item_o  (f_item)
  );

  i2cm_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  i2cm_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .phase_ticks_i (ticks_q),
    .cmd_valid_i   (q_valid),
    .cmd_ready_o   (q_ready),
    .cmd_item_i    (q_item),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o)
  );

endmodule

[hdl/i2cm_checker.sv]
// Port-level checker for the register-access I2C master, with its bind.
module i2cm_checker import i2cm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A read byte completes mid-transfer, before its ack bit
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.read_valid |-> out_item_o.busy_res)
    else $error("read byte reported outside a transfer");

  // A finished transfer leaves the master idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.done_res |-> !out_item_o.busy_res)
    else $error("done reported while still busy");

  // Nack status only comes with done
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status |-> out_item_o.done_res)
    else $error("status set without done");

  // Last-byte flag only marks a completed read byte
  a_last_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.last_byte |-> out_item_o.read_valid)
    else $error("last byte flag without a read byte");

endmodule

bind i2c_master_register_access i2cm_checker u_i2cm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
